// ----- hw/rtl/cbdq_pkg.sv -----
// Shared types and constants for the circular buffer deque.
// No dependencies; imported by cbdq_cell and circular_buffer_deque_unit.
`default_nettype none
package cbdq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY     = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_INS_REAR  = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_REAR  = 3'd4
  } act_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_r;   // insert front: every cell takes its left neighbor
    logic shift_l;   // delete front: every cell takes its right neighbor
    logic wr_rear;   // insert rear: the cell at the current count loads
  } cell_cmd_t;

  localparam logic [DATA_W-1:0] EMPTY_READ = '1;

endpackage
`default_nettype wire

// ----- hw/rtl/cbdq_cell.sv -----
// One storage cell of the deque chain; holds one element and passes it
// to its neighbors on shifts. Depends on cbdq_pkg.
`default_nettype none
module cbdq_cell
  import cbdq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  input  wire logic [CNT_W-1:0]  count_r,
  input  wire logic [CNT_W-1:0]  count_nxt,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0]      data_nxt,
  output logic                   rear_sel
);

  logic [DATA_W-1:0] data_r;

  always_comb begin
    data_nxt = data_r;
    priority if (cmd.shift_r) begin
      data_nxt = left_data;
    end else if (cmd.shift_l) begin
      data_nxt = right_data;
    end else if (cmd.wr_rear && (count_r == CNT_W'(IDX))) begin
      data_nxt = wr_data;
    end
  end

  // this cell holds the last element after the transfer
  assign rear_sel = (count_nxt == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/circular_buffer_deque_unit.sv -----
// Top level of the double-ended queue: a chain of cbdq_cell elements with
// the front fixed at cell 0, a fill counter and a registered result stage.
// Depends on cbdq_pkg and cbdq_cell.
//
//   channel   ports                         direction
//   in        in_valid/in_ready, action,    into block
//             value
//   out       out_valid/out_ready,          out of block
//             accepted, is_empty, is_full,
//             count, front_value, rear_value
//
// One item per cycle: the result of an item is registered at its transfer
// edge and offered from the next cycle; the cell row and counter update at
// that same edge.
// A new item is taken whenever the result register is empty or being read.
// Reset clears the fill count and result valid; cell contents are not reset.
// A stall on out holds the result and blocks in until it is taken.
`default_nettype none
module circular_buffer_deque_unit
  import cbdq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ACT_W-1:0]         in_action,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_accepted,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic [COUNT_OUT_W-1:0]        out_count,
  output logic signed [DATA_W-1:0]      out_front_value,
  output logic signed [DATA_W-1:0]      out_rear_value
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              xfer;
  logic              full, empty, ins_ok, del_ok;
  act_t              act;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data_nxt [CAPACITY];
  // current cell contents, as seen by the neighbors
  logic [DATA_W-1:0] cell_data_nxt_q [CAPACITY];
  logic [CAPACITY-1:0] rear_sel;
  logic [DATA_W-1:0] rear_mux;

  logic                     out_valid_r;
  logic                     accepted_r, is_empty_r, is_full_r;
  logic [COUNT_OUT_W-1:0]   count_out_r;
  logic [DATA_W-1:0]        front_r, rear_r;

  assign in_ready = !out_valid_r || out_ready;
  assign xfer     = in_valid && in_ready;
  assign act      = act_t'(in_action);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd    = '0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    if (xfer) begin
      unique case (act)
        ACT_INS_FRONT: begin
          ins_ok      = !full;
          cmd.shift_r = !full;
        end
        ACT_INS_REAR: begin
          ins_ok      = !full;
          cmd.wr_rear = !full;
        end
        ACT_DEL_FRONT: begin
          del_ok      = !empty;
          cmd.shift_l = !empty;
        end
        ACT_DEL_REAR: begin
          del_ok = !empty;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = cell_data_nxt_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data_nxt_q[i];
    end else begin : g_inner
      assign right_d = cell_data_nxt_q[i+1];
    end
    cbdq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count_r    (count_r),
      .count_nxt  (count_nxt),
      .left_data  (left_d),
      .right_data (right_d),
      .wr_data    (in_value),
      .data_nxt   (cell_data_nxt[i]),
      .rear_sel   (rear_sel[i])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_data_nxt_q[i] <= cell_data_nxt[i];
    end
  end

  // one-hot select of the last occupied cell
  always_comb begin
    rear_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rear_mux = rear_mux | ({DATA_W{rear_sel[i]}} & cell_data_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      accepted_r  <= ins_ok || del_ok;
      is_empty_r  <= (count_nxt == '0);
      is_full_r   <= (count_nxt == CNT_W'(CAPACITY));
      count_out_r <= COUNT_OUT_W'(count_nxt);
      front_r     <= (count_nxt == '0) ? EMPTY_READ : cell_data_nxt[0];
      rear_r      <= (count_nxt == '0) ? EMPTY_READ : rear_mux;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = accepted_r;
  assign out_is_empty    = is_empty_r;
  assign out_is_full     = is_full_r;
  assign out_count       = count_out_r;
  assign out_front_value = front_r;
  assign out_rear_value  = rear_r;

endmodule
`default_nettype wire

// ----- tb/sv/cbdq_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for circular_buffer_deque_unit: watches both channels, models the deque
// and compares every result transfer against the oldest predicted result.
// Depends on cbdq_pkg for widths, action codes and the empty-read value.
module cbdq_checker
  import cbdq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [DATA_W-1:0]      in_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_accepted,
  input  logic                   out_is_empty,
  input  logic                   out_is_full,
  input  logic [COUNT_OUT_W-1:0] out_count,
  input  logic [DATA_W-1:0]      out_front_value,
  input  logic [DATA_W-1:0]      out_rear_value,
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     full_seen,
  output int                     empty_seen,
  output int                     ignored_seen
);

  localparam int unsigned IDX_W = $clog2(CAPACITY_DEF);

  typedef struct packed {
    logic                   accepted;
    logic                   is_empty;
    logic                   is_full;
    logic [COUNT_OUT_W-1:0] count;
    logic [DATA_W-1:0]      front;
    logic [DATA_W-1:0]      rear;
  } deque_result_t;

  // Ring indexes wrap by truncation; capacity is a power of two.
  logic [DATA_W-1:0]      ring [CAPACITY_DEF];
  logic [IDX_W-1:0]       head;
  logic [COUNT_OUT_W-1:0] fill;
  deque_result_t          due_results [$];
  int errors   = 0;
  int n_chk    = 0;
  int n_full   = 0;
  int n_empty  = 0;
  int n_ignore = 0;

  function automatic deque_result_t apply_action(input logic [ACT_W-1:0] act,
                                                 input logic [DATA_W-1:0] val);
    deque_result_t    r;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (act)
      ACT_INS_FRONT: begin
        if (fill < CAPACITY_DEF) begin
          head = head - 1'b1;
          ring[head] = val;
          fill = fill + 1'b1;
          r.accepted = 1'b1;
        end
      end
      ACT_INS_REAR: begin
        if (fill < CAPACITY_DEF) begin
          slot = head + fill[IDX_W-1:0];
          ring[slot] = val;
          fill = fill + 1'b1;
          r.accepted = 1'b1;
        end
      end
      ACT_DEL_FRONT: begin
        if (fill != 0) begin
          head = head + 1'b1;
          fill = fill - 1'b1;
          r.accepted = 1'b1;
        end
      end
      ACT_DEL_REAR: begin
        if (fill != 0) begin
          fill = fill - 1'b1;
          r.accepted = 1'b1;
        end
      end
      default: ;  // query and spare codes leave the deque alone
    endcase
    r.is_empty = (fill == 0);
    r.is_full  = (fill >= CAPACITY_DEF);
    r.count    = fill;
    // at full the low index bits of fill are zero, so this still lands on head-1
    slot       = head + fill[IDX_W-1:0] - 1'b1;
    r.front    = r.is_empty ? EMPTY_READ : ring[head];
    r.rear     = r.is_empty ? EMPTY_READ : ring[slot];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    deque_result_t got;
    deque_result_t want;
    logic          bad;
    if (!rst_n) begin
      head = '0;
      fill = '0;
      due_results.delete();
    end else begin
      // the result of an item never leaves at its own transfer edge, so pop first
      if (out_valid && out_ready) begin
        got.accepted = out_accepted;
        got.is_empty = out_is_empty;
        got.is_full  = out_is_full;
        got.count    = out_count;
        got.front    = out_front_value;
        got.rear     = out_rear_value;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transfer with nothing outstanding", $time);
        end else begin
          want = due_results.pop_front();
          n_chk++;
          bad = (got.accepted !== want.accepted) || (got.is_empty !== want.is_empty) ||
                (got.is_full !== want.is_full) || (got.count !== want.count) ||
                (got.front !== want.front) || (got.rear !== want.rear);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp acc=%0b emp=%0b full=%0b cnt=%0d front=%h rear=%h",
                       $time, want.accepted, want.is_empty, want.is_full, want.count,
                       want.front, want.rear);
              $display("%0t:          got acc=%0b emp=%0b full=%0b cnt=%0d front=%h rear=%h",
                       $time, got.accepted, got.is_empty, got.is_full, got.count,
                       got.front, got.rear);
            end
          end
        end
        if (got.is_full) n_full++;
        if (got.is_empty) n_empty++;
        if (!got.accepted) n_ignore++;
      end
      if (in_valid && in_ready)
        due_results.push_back(apply_action(in_action, in_value));
    end
    fail_count   <= errors;
    pending      <= due_results.size();
    checked      <= n_chk;
    full_seen    <= n_full;
    empty_seen   <= n_empty;
    ignored_seen <= n_ignore;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Top of the deque testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on cbdq_pkg, circular_buffer_deque_unit and cbdq_checker.
module tb;
  import cbdq_pkg::*;

  localparam int ITEMS       = 1900;
  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 2000;

  // action codes the block treats as a query
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE} seg_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         in_action;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_accepted;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic [COUNT_OUT_W-1:0]   out_count;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_rear_value;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int ignored_seen;
  int sent        = 0;
  int quiet_count = 0;
  bit no_idle     = 1'b0;
  bit hold_req    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_buffer_deque_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value)
  );

  cbdq_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen),
    .ignored_seen    (ignored_seen)
  );

  // no transfer on either channel for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request so the block backs up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 14);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W-1){1'b0}}};
      3:       return {1'b0, {(DATA_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
    if (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  initial begin
    seg_t             seg;
    int               seg_len;
    int               next_hold;
    logic [ACT_W-1:0] act;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_QUERY;
    in_value  = '0;
    next_hold = 400;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-deque corners, head wrap, extreme values, spare codes
    send_item(ACT_QUERY, 32'h1234_5678);
    send_item(ACT_DEL_FRONT, '0);
    send_item(ACT_DEL_REAR, '1);
    send_item(ACT_INS_FRONT, 32'h8000_0000);
    send_item(ACT_INS_REAR, 32'h7FFF_FFFF);
    send_item(ACT_INS_FRONT, 32'hFFFF_FFFF);
    send_item(ACT_INS_REAR, 32'h0000_0000);
    send_item(ACT_QUERY, '0);
    send_item(ACT_SPARE_A, 32'hDEAD_BEEF);
    send_item(ACT_SPARE_B, 32'h0BAD_F00D);
    send_item(ACT_SPARE_C, '1);
    send_item(ACT_DEL_REAR, '0);
    send_item(ACT_DEL_FRONT, '0);
    send_item(ACT_DEL_REAR, '0);
    send_item(ACT_DEL_FRONT, '0);
    send_item(ACT_DEL_FRONT, '0);
    send_item(ACT_INS_REAR, 32'hA5A5_5A5A);
    send_item(ACT_DEL_FRONT, '0);
    send_item(ACT_INS_FRONT, 32'h5A5A_A5A5);
    send_item(ACT_DEL_REAR, '0);

    // fill past full, then drain past empty, before going random
    repeat (19) send_item($urandom_range(1) ? ACT_INS_FRONT : ACT_INS_REAR, pick_value());
    repeat (19) send_item($urandom_range(1) ? ACT_DEL_FRONT : ACT_DEL_REAR, pick_value());

    while (sent < ITEMS) begin
      no_idle = (sent >= 800 && sent < 1100);
      if (sent >= next_hold) begin
        hold_req  = 1'b1;
        next_hold = next_hold + 1100;
      end
      case ($urandom_range(9))
        0, 1, 2: seg = SEG_FILL;
        3, 4, 5: seg = SEG_DRAIN;
        6, 7, 8: seg = SEG_MIXED;
        default: seg = SEG_NOISE;
      endcase
      seg_len = (seg == SEG_FILL || seg == SEG_DRAIN) ? $urandom_range(20, 17)
                                                      : $urandom_range(40, 10);
      for (int k = 0; k < seg_len; k++) begin
        case (seg)
          SEG_FILL:
            act = ($urandom_range(9) == 0) ? ACT_QUERY :
                  ($urandom_range(1) ? ACT_INS_FRONT : ACT_INS_REAR);
          SEG_DRAIN:
            act = ($urandom_range(9) == 0) ? ACT_QUERY :
                  ($urandom_range(1) ? ACT_DEL_FRONT : ACT_DEL_REAR);
          SEG_MIXED: act = ACT_W'($urandom_range(ACT_DEL_REAR, ACT_QUERY));
          default:   act = ACT_W'($urandom_range(ACT_SPARE_C, ACT_QUERY));
        endcase
        send_item(act, pick_value());
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d actions sent, %0d results checked, incl. back-pressure stalls", sent, checked);
    $display("deque seen full %0d times, empty %0d times, %0d actions ignored",
             full_seen, empty_seen, ignored_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cbdq_pkg.sv
hw/rtl/cbdq_cell.sv
hw/rtl/circular_buffer_deque_unit.sv
tb/sv/cbdq_checker.sv
tb/sv/tb.sv
